// ----- rtl/tpi_pkg.sv -----
`default_nettype none
package tpi_pkg;

	localparam int NODE_W     = 6;
	localparam int IDX_W      = 6;
	localparam int CNT_W      = 7;
	localparam int DIST_W     = 16;
	localparam int GAIN_W     = DIST_W + 1;
	localparam int PASS_W     = 13;
	localparam int MAX_PATH   = 64;
	localparam int PASS_LIMIT = 4096;

	typedef enum logic [1:0] {
		FUNC_DIST   = 2'd0,
		FUNC_APPEND = 2'd1,
		FUNC_START  = 2'd2,
		FUNC_NONE   = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		RA_A  = 3'd0,
		RA_A1 = 3'd1,
		RA_B  = 3'd2,
		RA_B1 = 3'd3,
		RA_LO = 3'd4,
		RA_HI = 3'd5,
		RA_K  = 3'd6
	} rsel_t;

	typedef enum logic [1:0] {
		DA_PA_PA1  = 2'd0,
		DA_PB_PB1  = 2'd1,
		DA_PA_PB   = 2'd2,
		DA_PA1_PB1 = 2'd3
	} dsel_t;

	typedef struct packed {
		rsel_t rsel;
		dsel_t dsel;
		logic  take;
		logic  start;
		logic  cap_pa;
		logic  cap_pa1;
		logic  cap_pb;
		logic  cap_pb1;
		logic  cur_ld;
		logic  cur_add;
		logic  nw_ld;
		logic  nw_add;
		logic  adv;
		logic  first_swap;
		logic  best_upd;
		logic  best_swap;
		logic  tmp_ld;
		logic  wr_lo;
		logic  wr_hi;
		logic  swap_step;
		logic  pass_next;
		logic  emit_ld;
		logic  count_clr;
	} cmd_t;

	typedef struct packed {
		logic mode;
		logic empty;
		logic short_path;
		logic b_more;
		logic a_more;
		logic improving;
		logic better;
		logic improved;
		logic pass_more;
		logic swap_more;
		logic emit_last;
		logic out_free;
	} sts_t;

endpackage
`default_nettype wire

// ----- rtl/tpi_if.sv -----
`default_nettype none
interface tpi_in_if;
	logic                       valid;
	logic                       ready;
	logic [1:0]                 func;
	logic [tpi_pkg::NODE_W-1:0] from_node;
	logic [tpi_pkg::NODE_W-1:0] to_node;
	logic [tpi_pkg::DIST_W-1:0] distance;
	logic [tpi_pkg::NODE_W-1:0] path_node;

	modport source (output valid, func, from_node, to_node, distance, path_node, input ready);
	modport sink (input valid, func, from_node, to_node, distance, path_node, output ready);
endinterface

interface tpi_out_if;
	logic                       valid;
	logic                       ready;
	logic [tpi_pkg::NODE_W-1:0] out_node;
	logic [tpi_pkg::IDX_W-1:0]  position;
	logic                       last_of_run;

	modport source (output valid, out_node, position, last_of_run, input ready);
	modport sink (input valid, out_node, position, last_of_run, output ready);
endinterface
`default_nettype wire

// ----- rtl/tpi_datapath.sv -----
`default_nettype none
module tpi_datapath (
	input  wire                        clk,
	input  wire                        arst_n,
	input  tpi_pkg::cmd_t              cmd,
	output tpi_pkg::sts_t              sts,
	input  wire [1:0]                  func,
	input  wire [tpi_pkg::NODE_W-1:0]  from_node,
	input  wire [tpi_pkg::NODE_W-1:0]  to_node,
	input  wire [tpi_pkg::DIST_W-1:0]  distance,
	input  wire [tpi_pkg::NODE_W-1:0]  path_node,
	input  wire                        cfg_we,
	input  wire                        cfg_wdata,
	input  wire                        out_ready,
	output logic                       out_valid,
	output logic [tpi_pkg::NODE_W-1:0] out_node,
	output logic [tpi_pkg::IDX_W-1:0]  position,
	output logic                       last_of_run
);
	import tpi_pkg::*;

	localparam int DADDR_W = 2 * NODE_W;
	localparam int CMP_W   = CNT_W + 1;

	logic [DIST_W-1:0] dist_mem [2**DADDR_W];
	logic [NODE_W-1:0] path_mem [MAX_PATH];

	logic              mode_q;
	logic [CNT_W-1:0]  count_q;
	logic [IDX_W-1:0]  a_q, b_q, lo_q, hi_q, k_q;
	logic [NODE_W-1:0] pa_q, pa1_q, pb_q, pb1_q, tmp_q;
	logic [GAIN_W-1:0] cur_q, nw_q, best_gain_q;
	logic [IDX_W-1:0]  best_start_q, best_end_q;
	logic              improved_q;
	logic [PASS_W-1:0] passes_q;
	logic [NODE_W-1:0] prd_q;
	logic [DIST_W-1:0] drd_q;
	logic              out_v_q;
	logic [NODE_W-1:0] out_node_q;
	logic [IDX_W-1:0]  pos_q;
	logic              last_q;

	logic [IDX_W-1:0]   raddr;
	logic [DADDR_W-1:0] daddr;
	logic               pwe;
	logic [IDX_W-1:0]   pwaddr;
	logic [NODE_W-1:0]  pwdata;
	logic [GAIN_W-1:0]  gain;
	logic               dist_we;

	always_comb begin
		case (cmd.rsel)
			RA_A:    raddr = a_q;
			RA_A1:   raddr = a_q + IDX_W'(1);
			RA_B:    raddr = b_q;
			RA_B1:   raddr = b_q + IDX_W'(1);
			RA_LO:   raddr = lo_q;
			RA_HI:   raddr = hi_q;
			RA_K:    raddr = k_q;
			default: raddr = k_q;
		endcase
		case (cmd.dsel)
			DA_PA_PA1:  daddr = {pa_q, pa1_q};
			DA_PB_PB1:  daddr = {pb_q, pb1_q};
			DA_PA_PB:   daddr = {pa_q, pb_q};
			DA_PA1_PB1: daddr = {pa1_q, pb1_q};
			default:    daddr = {pa_q, pa1_q};
		endcase
	end

	always_comb begin
		pwe    = 1'b0;
		pwaddr = lo_q;
		pwdata = prd_q;
		if (cmd.take && func == FUNC_APPEND && count_q < CNT_W'(MAX_PATH)) begin
			pwe    = 1'b1;
			pwaddr = count_q[IDX_W-1:0];
			pwdata = path_node;
		end else if (cmd.wr_lo) begin
			pwe = 1'b1;
		end else if (cmd.wr_hi) begin
			pwe    = 1'b1;
			pwaddr = hi_q;
			pwdata = tmp_q;
		end
	end

	assign dist_we = cmd.take && func == FUNC_DIST;

	always_ff @(posedge clk) begin
		if (dist_we) begin
			dist_mem[{from_node, to_node}] <= distance;
		end
		drd_q <= dist_mem[daddr];
	end

	always_ff @(posedge clk) begin
		if (pwe) begin
			path_mem[pwaddr] <= pwdata;
		end
		prd_q <= path_mem[raddr];
	end

	assign gain = cur_q - nw_q;

	always_ff @(posedge clk) begin
		if (cmd.cap_pa) pa_q <= prd_q;
		if (cmd.cap_pa1) pa1_q <= prd_q;
		if (cmd.cap_pb) pb_q <= prd_q;
		if (cmd.cap_pb1) pb1_q <= prd_q;
		if (cmd.cur_ld) cur_q <= GAIN_W'(drd_q);
		if (cmd.cur_add) cur_q <= cur_q + GAIN_W'(drd_q);
		if (cmd.nw_ld) nw_q <= GAIN_W'(drd_q);
		if (cmd.nw_add) nw_q <= nw_q + GAIN_W'(drd_q);
		if (cmd.tmp_ld) tmp_q <= prd_q;
		if (cmd.first_swap) begin
			lo_q <= a_q + IDX_W'(1);
			hi_q <= b_q;
		end else if (cmd.best_swap) begin
			lo_q <= best_start_q;
			hi_q <= best_end_q;
		end else if (cmd.swap_step) begin
			lo_q <= lo_q + IDX_W'(1);
			hi_q <= hi_q - IDX_W'(1);
		end
		if (cmd.emit_ld) begin
			out_node_q <= prd_q;
			pos_q      <= k_q;
			last_q     <= sts.emit_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= 1'b0;
			count_q      <= '0;
			a_q          <= '0;
			b_q          <= '0;
			k_q          <= '0;
			improved_q   <= 1'b0;
			best_gain_q  <= '0;
			best_start_q <= '0;
			best_end_q   <= '0;
			passes_q     <= '0;
			out_v_q      <= 1'b0;
		end else begin
			if (cfg_we) mode_q <= cfg_wdata;
			if (cmd.take && func == FUNC_APPEND && count_q < CNT_W'(MAX_PATH)) begin
				count_q <= count_q + CNT_W'(1);
			end
			if (cmd.count_clr) count_q <= '0;
			if (cmd.start || cmd.pass_next) begin
				a_q          <= '0;
				b_q          <= IDX_W'(2);
				improved_q   <= 1'b0;
				best_gain_q  <= '0;
				best_start_q <= '0;
				best_end_q   <= '0;
				k_q          <= '0;
				passes_q     <= cmd.start ? '0 : passes_q + PASS_W'(1);
			end
			if (cmd.adv) begin
				if (sts.b_more) begin
					b_q <= b_q + IDX_W'(1);
				end else begin
					a_q <= a_q + IDX_W'(1);
					b_q <= a_q + IDX_W'(3);
				end
			end
			if (cmd.first_swap) improved_q <= 1'b1;
			if (cmd.best_upd) begin
				improved_q   <= 1'b1;
				best_gain_q  <= gain;
				best_start_q <= a_q + IDX_W'(1);
				best_end_q   <= b_q;
			end
			if (cmd.emit_ld) begin
				k_q     <= k_q + IDX_W'(1);
				out_v_q <= 1'b1;
			end else if (out_ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_comb begin
		sts.mode       = mode_q;
		sts.empty      = count_q == '0;
		sts.short_path = count_q < CNT_W'(4);
		sts.b_more     = (CMP_W'(b_q) + CMP_W'(3)) <= CMP_W'(count_q);
		sts.a_more     = (CMP_W'(a_q) + CMP_W'(5)) <= CMP_W'(count_q);
		sts.improving  = nw_q < cur_q;
		sts.better     = gain > best_gain_q;
		sts.improved   = improved_q;
		sts.pass_more  = improved_q && (passes_q < PASS_W'(PASS_LIMIT - 1));
		sts.swap_more  = (CMP_W'(lo_q) + CMP_W'(2)) < CMP_W'(hi_q);
		sts.emit_last  = (CMP_W'(k_q) + CMP_W'(1)) == CMP_W'(count_q);
		sts.out_free   = !out_v_q || out_ready;
	end

	assign out_valid   = out_v_q;
	assign out_node    = out_node_q;
	assign position    = pos_q;
	assign last_of_run = last_q;

endmodule
`default_nettype wire

// ----- rtl/tpi_controller.sv -----
`default_nettype none
module tpi_controller (
	input  wire           clk,
	input  wire           arst_n,
	input  wire           in_valid,
	input  wire [1:0]     in_func,
	output logic          in_ready,
	input  tpi_pkg::sts_t sts,
	output tpi_pkg::cmd_t cmd
);
	import tpi_pkg::*;

	typedef enum logic [18:0] {
		S_IDLE  = 19'd1 << 0,
		S_RD0   = 19'd1 << 1,
		S_RD1   = 19'd1 << 2,
		S_RD2   = 19'd1 << 3,
		S_RD3   = 19'd1 << 4,
		S_D0    = 19'd1 << 5,
		S_D1    = 19'd1 << 6,
		S_D2    = 19'd1 << 7,
		S_D3    = 19'd1 << 8,
		S_EV    = 19'd1 << 9,
		S_CMP   = 19'd1 << 10,
		S_ADV   = 19'd1 << 11,
		S_SW0   = 19'd1 << 12,
		S_SW1   = 19'd1 << 13,
		S_SW2   = 19'd1 << 14,
		S_SW3   = 19'd1 << 15,
		S_PEND  = 19'd1 << 16,
		S_PNEXT = 19'd1 << 17,
		S_EMIT  = 19'd1 << 18
	} state_t;

	state_t state_q, state_d;
	logic   emit_wait_q, emit_wait_d;

	assign in_ready = state_q == S_IDLE;

	always_comb begin
		cmd         = '0;
		cmd.rsel    = RA_K;
		cmd.dsel    = DA_PA_PA1;
		state_d     = state_q;
		emit_wait_d = emit_wait_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.take = 1'b1;
					if (in_func == FUNC_START) begin
						cmd.start = 1'b1;
						if (sts.empty) begin
							state_d = S_IDLE;
						end else if (sts.short_path) begin
							state_d     = S_EMIT;
							emit_wait_d = 1'b0;
						end else begin
							state_d = S_RD0;
						end
					end
				end
			end
			S_RD0: begin
				cmd.rsel = RA_A;
				state_d  = S_RD1;
			end
			S_RD1: begin
				cmd.rsel   = RA_A1;
				cmd.cap_pa = 1'b1;
				state_d    = S_RD2;
			end
			S_RD2: begin
				cmd.rsel    = RA_B;
				cmd.cap_pa1 = 1'b1;
				state_d     = S_RD3;
			end
			S_RD3: begin
				cmd.rsel   = RA_B1;
				cmd.cap_pb = 1'b1;
				state_d    = S_D0;
			end
			S_D0: begin
				cmd.cap_pb1 = 1'b1;
				cmd.dsel    = DA_PA_PA1;
				state_d     = S_D1;
			end
			S_D1: begin
				cmd.dsel   = DA_PB_PB1;
				cmd.cur_ld = 1'b1;
				state_d    = S_D2;
			end
			S_D2: begin
				cmd.dsel    = DA_PA_PB;
				cmd.cur_add = 1'b1;
				state_d     = S_D3;
			end
			S_D3: begin
				cmd.dsel  = DA_PA1_PB1;
				cmd.nw_ld = 1'b1;
				state_d   = S_EV;
			end
			S_EV: begin
				cmd.nw_add = 1'b1;
				state_d    = S_CMP;
			end
			S_CMP: begin
				if (!sts.mode && sts.improving) begin
					cmd.first_swap = 1'b1;
					state_d        = S_SW0;
				end else begin
					cmd.best_upd = sts.mode && sts.improving && sts.better;
					cmd.adv      = 1'b1;
					state_d      = (sts.b_more || sts.a_more) ? S_RD0 : S_PEND;
				end
			end
			S_ADV: begin
				cmd.adv = 1'b1;
				state_d = (sts.b_more || sts.a_more) ? S_RD0 : S_PEND;
			end
			S_SW0: begin
				cmd.rsel = RA_LO;
				state_d  = S_SW1;
			end
			S_SW1: begin
				cmd.rsel   = RA_HI;
				cmd.tmp_ld = 1'b1;
				state_d    = S_SW2;
			end
			S_SW2: begin
				cmd.wr_lo = 1'b1;
				state_d   = S_SW3;
			end
			S_SW3: begin
				cmd.wr_hi     = 1'b1;
				cmd.swap_step = 1'b1;
				if (sts.swap_more) begin
					state_d = S_SW0;
				end else begin
					state_d = sts.mode ? S_PNEXT : S_ADV;
				end
			end
			S_PEND: begin
				if (sts.mode && sts.improved) begin
					cmd.best_swap = 1'b1;
					state_d       = S_SW0;
				end else begin
					state_d = S_PNEXT;
				end
			end
			S_PNEXT: begin
				cmd.pass_next = 1'b1;
				if (sts.pass_more) begin
					state_d = S_RD0;
				end else begin
					state_d     = S_EMIT;
					emit_wait_d = 1'b0;
				end
			end
			S_EMIT: begin
				cmd.rsel = RA_K;
				if (!emit_wait_q) begin
					emit_wait_d = 1'b1;
				end else if (sts.out_free) begin
					cmd.emit_ld = 1'b1;
					emit_wait_d = 1'b0;
					if (sts.emit_last) begin
						cmd.count_clr = 1'b1;
						state_d       = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			emit_wait_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			emit_wait_q <= emit_wait_d;
		end
	end

endmodule
`default_nettype wire

// ----- rtl/two_opt_path_improver.sv -----
// Load items (distance write, node append) are taken in the idle state and leave it idle.
// A start item on four or more nodes reads four path nodes and sums four distances per
// candidate swap, swaps the node pairs of each accepted move and closes each pass, over
// at most 4096 passes, in steps set by the single-read-port path store and the registered
// distance table read; the path is then emitted node by node while the result is ready.
// Reset clears the control state, the path length and the mode; the tables hold garbage.
`default_nettype none
module two_opt_path_improver (
	input  wire            clk,
	input  wire            arst_n,
	tpi_in_if.sink         item,
	tpi_out_if.source      result,
	input  wire            cfg_we,
	input  wire            cfg_wdata
);
	import tpi_pkg::*;

	cmd_t cmd;
	sts_t sts;

	tpi_controller u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (item.valid),
		.in_func  (item.func),
		.in_ready (item.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	tpi_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.func        (item.func),
		.from_node   (item.from_node),
		.to_node     (item.to_node),
		.distance    (item.distance),
		.path_node   (item.path_node),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.out_ready   (result.ready),
		.out_valid   (result.valid),
		.out_node    (result.out_node),
		.position    (result.position),
		.last_of_run (result.last_of_run)
	);

endmodule
`default_nettype wire

// ----- rtl/tpi_checker.sv -----
`default_nettype none
module tpi_checker (
	input wire                        clk,
	input wire                        arst_n,
	input wire                        in_valid,
	input wire                        in_ready,
	input wire [1:0]                  in_func,
	input wire                        out_valid,
	input wire                        out_ready,
	input wire [tpi_pkg::NODE_W-1:0]  out_node,
	input wire [tpi_pkg::IDX_W-1:0]   position,
	input wire                        last_of_run
);
	import tpi_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_node) && $stable(position)
			&& $stable(last_of_run))
		else $error("result changed while stalled");

	a_busy_mid_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last_of_run |-> !in_ready)
		else $error("input taken in the middle of an emitted path");

	a_load_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (in_func == FUNC_DIST || in_func == FUNC_APPEND)
			|=> in_ready)
		else $error("load transfer did not return to idle");

	a_last_gap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && last_of_run |=> !out_valid || position == '0)
		else $error("result after the final node does not start a new path");

endmodule

bind two_opt_path_improver tpi_checker u_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (item.valid),
	.in_ready    (item.ready),
	.in_func     (item.func),
	.out_valid   (result.valid),
	.out_ready   (result.ready),
	.out_node    (result.out_node),
	.position    (result.position),
	.last_of_run (result.last_of_run)
);
`default_nettype wire
